### rtl/conv3x3_divide_offset_clamp_assert.svh
// Assertion macros shared by the filter RTL.
`ifndef CONV3X3_DIVIDE_OFFSET_CLAMP_ASSERT_SVH
`define CONV3X3_DIVIDE_OFFSET_CLAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C3DOC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C3DOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/c3doc_pkg.sv
package c3doc_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);

	localparam int PIX_W     = 8;
	localparam int KROW_W    = 24;
	localparam int DIV_W     = 8;
	localparam int OFF_W     = 9;
	localparam int WID_W     = 11;
	localparam int HGT_W     = 16;
	localparam int CFG_IDX_W = 3;

	// geometry compares run at a width that holds both the register and MAX_WIDTH
	localparam int CMP_W = (COL_W + 1 > WID_W) ? COL_W + 1 : WID_W;

	// |sum| <= 9 * 255 * 128 fits 19 bits; signed accumulator takes one more
	localparam int MAG_W    = 19;
	localparam int ACC_W    = MAG_W + 1;
	localparam int PROD_W   = 17;
	localparam int DCNT_W   = $clog2(MAG_W);

	localparam logic [KROW_W-1:0] KERNEL_TOP_RST    = 24'd0;
	localparam logic [KROW_W-1:0] KERNEL_MIDDLE_RST = 24'd256;
	localparam logic [KROW_W-1:0] KERNEL_BOTTOM_RST = 24'd0;
	localparam logic [DIV_W-1:0]  DIVISOR_RST       = 8'd1;
	localparam logic [OFF_W-1:0]  OFFSET_RST        = 9'd0;
	localparam logic [WID_W-1:0]  WIDTH_RST         = 11'd1024;
	localparam logic [HGT_W-1:0]  HEIGHT_RST        = 16'd1024;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL_TOP,
		CFG_KERNEL_MIDDLE,
		CFG_KERNEL_BOTTOM,
		CFG_DIVISOR,
		CFG_OFFSET,
		CFG_WIDTH,
		CFG_HEIGHT
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

### rtl/conv3x3_divide_offset_clamp.sv
// 3x3 convolution with divide, offset and clamp over an 8-bit grayscale stream.
// Input channel: in_valid / in_stall with pixel_in, one pixel per item in raster order.
// Output channel: out_valid / out_stall with pixel_out and frame_last, one result
// for each interior pixel; frame_last marks the final result of the image.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Write only while the block is idle.
// Sequence: a border pixel occupies the block for its accept and the line store
// read-modify-write. An interior pixel occupies it through the accept, the line
// store access, 9 multiply-accumulate steps on the single multiplier, a step
// to take the magnitude, 19 steps of the bit-serial divider and the load of
// the output register. Its result is visible in the cycle after that load.
// The next item is accepted once the previous result sits in the output
// register; if that register is still stalled when a new result is ready,
// in_stall stays high until the waiting result is taken.
// Reset: configuration returns to its defaults, row and column go to zero and
// the output register empties. The line stores are not cleared: the first two
// rows of each image fill them before any result reads them.
`include "conv3x3_divide_offset_clamp_assert.svh"

module conv3x3_divide_offset_clamp
	import c3doc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 frame_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KROW_W-1:0]    cfg_data
);

	state_t state_q, state_d;

	logic [KROW_W-1:0] kern_top_q, kern_mid_q, kern_bot_q;
	logic [DIV_W-1:0]  divisor_q;
	logic [OFF_W-1:0]  offset_q;
	logic [WID_W-1:0]  width_q;
	logic [HGT_W-1:0]  height_q;

	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;

	logic             in_accept;
	logic [CMP_W-1:0] w_ext, w_eff;
	logic [HGT_W-1:0] h_eff;
	logic             row_end, frame_end, interior;

	logic [PIX_W-1:0] pix_s1;
	logic [COL_W-1:0] col_s1;
	logic             interior_s1, frame_end_s1;

	logic             ram_we;
	logic [PIX_W-1:0] up_rd, lo_rd;

	logic [PIX_W-1:0] win_q  [0:5];
	logic [PIX_W-1:0] ncol_q [0:2];

	logic [1:0]              mac_row_q, mac_col_q;
	logic                    mac_last;
	logic [PIX_W-1:0]        tap_pix;
	logic [KROW_W-1:0]       krow;
	logic [7:0]              coef;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]         acc_neg;
	logic [MAG_W-1:0]         mag;

	logic [MAG_W-1:0]  quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic              neg_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              div_last;
	logic [DIV_W-1:0]  d_eff;
	logic [DIV_W:0]    trial, d_ext;
	logic              fits;

	logic signed [ACC_W-1:0] qs;
	logic signed [ACC_W:0]   vsum;
	logic [PIX_W-1:0]        clamped;

	logic             out_load;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_out_q;
	logic             frame_last_q;

	assign cfg_ready = 1'b1;
	assign in_accept = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_top_q <= KERNEL_TOP_RST;
			kern_mid_q <= KERNEL_MIDDLE_RST;
			kern_bot_q <= KERNEL_BOTTOM_RST;
			divisor_q  <= DIVISOR_RST;
			offset_q   <= OFFSET_RST;
			width_q    <= WIDTH_RST;
			height_q   <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KERNEL_TOP:    kern_top_q <= cfg_data;
				CFG_KERNEL_MIDDLE: kern_mid_q <= cfg_data;
				CFG_KERNEL_BOTTOM: kern_bot_q <= cfg_data;
				CFG_DIVISOR:       divisor_q  <= cfg_data[DIV_W-1:0];
				CFG_OFFSET:        offset_q   <= cfg_data[OFF_W-1:0];
				CFG_WIDTH:         width_q    <= cfg_data[WID_W-1:0];
				CFG_HEIGHT:        height_q   <= cfg_data[HGT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Geometry of the item being accepted
	always_comb begin
		w_ext = CMP_W'(width_q);
		if (w_ext < CMP_W'(3)) begin
			w_eff = CMP_W'(3);
		end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
		h_eff     = (height_q < HGT_W'(3)) ? HGT_W'(3) : height_q;
		row_end   = CMP_W'(col_q) >= (w_eff - CMP_W'(1));
		frame_end = row_end && (row_q >= (h_eff - HGT_W'(1)));
		interior  = (row_q >= HGT_W'(2)) && (col_q >= COL_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + HGT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interior_s1 <= 1'b0;
		end else if (in_accept) begin
			interior_s1 <= interior;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pix_s1       <= pixel_in;
			col_s1       <= col_q;
			frame_end_s1 <= frame_end;
		end
	end

	// Line stores: read at accept, write back in the cycle after
	c3doc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (lo_rd),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (up_rd)
	);

	c3doc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (pix_s1),
		.re    (in_accept),
		.raddr (col_q),
		.rdata (lo_rd)
	);

	// Sequencer
	assign mac_last = (state_q == ST_MAC) && (mac_row_q == 2'd2) && (mac_col_q == 2'd2);
	assign div_last = (cnt_q == DCNT_W'(MAG_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ram_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_we  = 1'b1;
				state_d = interior_s1 ? ST_MAC : ST_IDLE;
			end
			ST_MAC: begin
				if (mac_last) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Window: shift in the new column once the item no longer needs the old one
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			ncol_q[0] <= up_rd;
			ncol_q[1] <= lo_rd;
			ncol_q[2] <= pix_s1;
			if (!interior_s1) begin
				for (int k = 0; k < 3; k++) begin
					win_q[k] <= win_q[k+3];
				end
				win_q[3] <= up_rd;
				win_q[4] <= lo_rd;
				win_q[5] <= pix_s1;
			end
		end else if (mac_last) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k]   <= win_q[k+3];
				win_q[k+3] <= ncol_q[k];
			end
		end
	end

	// One tap per cycle through the multiplier
	always_comb begin
		unique case (mac_row_q)
			2'd0:    krow = kern_top_q;
			2'd1:    krow = kern_mid_q;
			2'd2:    krow = kern_bot_q;
			default: krow = '0;
		endcase
		unique case (mac_col_q)
			2'd0: begin
				tap_pix = win_q[3'(mac_row_q)];
				coef    = krow[7:0];
			end
			2'd1: begin
				tap_pix = win_q[3'(mac_row_q) + 3'd3];
				coef    = krow[15:8];
			end
			2'd2: begin
				tap_pix = ncol_q[mac_row_q];
				coef    = krow[23:16];
			end
			default: begin
				tap_pix = '0;
				coef    = '0;
			end
		endcase
		prod    = PROD_W'($signed({1'b0, tap_pix})) * PROD_W'($signed(coef));
		acc_neg = -acc_q;
		mag     = acc_q[ACC_W-1] ? acc_neg[MAG_W-1:0] : acc_q[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_row_q <= '0;
			mac_col_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (state_q == ST_READ) begin
				mac_row_q <= '0;
				mac_col_q <= '0;
			end else if (state_q == ST_MAC) begin
				if (mac_row_q == 2'd2) begin
					mac_row_q <= '0;
					mac_col_q <= mac_col_q + 2'd1;
				end else begin
					mac_row_q <= mac_row_q + 2'd1;
				end
			end
			if (state_q == ST_PREP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + DCNT_W'(1);
			end
		end
	end

	// Restoring divider on the magnitude, one quotient bit per cycle
	always_comb begin
		d_eff = (divisor_q == '0) ? DIV_W'(1) : divisor_q;
		d_ext = {1'b0, d_eff};
		trial = {rem_q, quo_q[MAG_W-1]};
		fits  = trial >= d_ext;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			acc_q <= '0;
		end else if (state_q == ST_MAC) begin
			acc_q <= acc_q + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		end
		if (state_q == ST_PREP) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= acc_q[ACC_W-1];
		end else if (state_q == ST_DIV) begin
			if (fits) begin
				rem_q <= DIV_W'(trial - d_ext);
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	// Restore sign, add offset, saturate
	always_comb begin
		qs   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		vsum = $signed({qs[ACC_W-1], qs}) +
			$signed({{(ACC_W+1-OFF_W){offset_q[OFF_W-1]}}, offset_q});
		if (vsum[ACC_W]) begin
			clamped = '0;
		end else if (vsum > $signed((ACC_W+1)'(255))) begin
			clamped = 8'd255;
		end else begin
			clamped = vsum[PIX_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q  <= clamped;
			frame_last_q <= frame_end_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign frame_last = frame_last_q;

	`C3DOC_ASSERT_NEXT(a_accept_reads, clk, arst_n, in_valid && !in_stall, state_q == ST_READ, "accepted item did not start a line store access")
	`C3DOC_ASSERT_IMPLY(a_mac_interior, clk, arst_n, state_q == ST_MAC, interior_s1, "multiply-accumulate running for a border pixel")
	`C3DOC_ASSERT_NEXT(a_frame_wrap, clk, arst_n, in_valid && !in_stall && frame_end, col_q == '0 && row_q == '0, "positions not cleared after the last pixel of an image")
	`C3DOC_ASSERT_NEXT(a_result_loaded, clk, arst_n, out_load, out_valid && state_q == ST_IDLE, "finished result not presented at the output")

endmodule

### rtl/c3doc_ram.sv
module c3doc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### tb/sv/conv3x3_divide_offset_clamp_tb.sv
module conv3x3_divide_offset_clamp_tb
	import c3doc_pkg::*;
;

	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 280;

	// named filters: rows packed left column in the low byte
	localparam logic [KROW_W-1:0] SHARPEN_OUTER = 24'hFFFFFF;
	localparam logic [KROW_W-1:0] SHARPEN_CENTRE = 24'hFF09FF;
	localparam logic [KROW_W-1:0] SOBEL_OUTER = 24'hFF0001;
	localparam logic [KROW_W-1:0] SOBEL_CENTRE = 24'hFE0002;
	localparam logic [KROW_W-1:0] CROSS_OUTER = 24'h00FF00;
	localparam logic [KROW_W-1:0] CROSS_CENTRE = 24'hFF05FF;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
	} filtered_t;

	class conv_scoreboard;
		logic [KROW_W-1:0] kernel_rows [3];
		logic [DIV_W-1:0]  divisor;
		logic [OFF_W-1:0]  offset;
		logic [WID_W-1:0]  width_reg;
		logic [HGT_W-1:0]  height_reg;
		logic [PIX_W-1:0]  upper_row [MAX_WIDTH];
		logic [PIX_W-1:0]  lower_row [MAX_WIDTH];
		logic [PIX_W-1:0]  window [6];
		int unsigned       col_pos;
		int unsigned       row_pos;
		filtered_t         expected_pixels [$];
		int                errors;

		function new();
			kernel_rows[0] = KERNEL_TOP_RST;
			kernel_rows[1] = KERNEL_MIDDLE_RST;
			kernel_rows[2] = KERNEL_BOTTOM_RST;
			divisor = DIVISOR_RST;
			offset = OFFSET_RST;
			width_reg = WIDTH_RST;
			height_reg = HEIGHT_RST;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				lower_row[i] = '0;
			end
			foreach (window[i])
				window[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return expected_pixels.size();
		endfunction

		function void write_reg(cfg_idx_t idx, logic [KROW_W-1:0] data);
			case (idx)
				CFG_KERNEL_TOP:    kernel_rows[0] = data;
				CFG_KERNEL_MIDDLE: kernel_rows[1] = data;
				CFG_KERNEL_BOTTOM: kernel_rows[2] = data;
				CFG_DIVISOR:       divisor = data[DIV_W-1:0];
				CFG_OFFSET:        offset = data[OFF_W-1:0];
				CFG_WIDTH:         width_reg = data[WID_W-1:0];
				CFG_HEIGHT:        height_reg = data[HGT_W-1:0];
				default: ;
			endcase
		endfunction

		function int coefficient(int k, int j);
			return int'($signed(kernel_rows[k][8*j +: 8]));
		endfunction

		// advance the window by one pixel and queue the filtered value if interior
		function void note_pixel(logic [PIX_W-1:0] value);
			int unsigned cols, rows, c, r;
			logic [PIX_W-1:0] column [3];
			int sum, dvs, level;
			bit row_end, frame_end;
			filtered_t item;
			cols = width_reg;
			if (cols < 3) cols = 3;
			if (cols > MAX_WIDTH) cols = MAX_WIDTH;
			rows = height_reg;
			if (rows < 3) rows = 3;
			c = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
			r = row_pos;
			column[0] = upper_row[c];
			column[1] = lower_row[c];
			column[2] = value;
			upper_row[c] = column[1];
			lower_row[c] = column[2];
			row_end = (c >= cols - 1);
			frame_end = row_end && (r >= rows - 1);
			if (r >= 2 && c >= 2) begin
				sum = 0;
				for (int k = 0; k < 3; k++) begin
					sum += int'(window[k]) * coefficient(k, 0);
					sum += int'(window[3+k]) * coefficient(k, 1);
					sum += int'(column[k]) * coefficient(k, 2);
				end
				dvs = (divisor == 0) ? 1 : int'(divisor);
				level = sum / dvs + int'($signed(offset));
				if (level > 255) level = 255;
				if (level < 0) level = 0;
				item.pixel = level[PIX_W-1:0];
				item.last = frame_end;
				expected_pixels = {expected_pixels, item};
			end
			for (int k = 0; k < 3; k++) begin
				window[k] = window[3+k];
				window[3+k] = column[k];
			end
			if (row_end) begin
				col_pos = 0;
				row_pos = frame_end ? 0 : ((r + 1) & 16'hFFFF);
			end else begin
				col_pos = c + 1;
			end
		endfunction

		task check_result(logic [PIX_W-1:0] pixel, logic last);
			filtered_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result %0d with none expected", pixel));
				return;
			end
			want = expected_pixels.pop_front();
			if (pixel !== want.pixel)
				report($sformatf("pixel_out %0d, expected %0d", pixel, want.pixel));
			if (last !== want.last)
				report($sformatf("frame_last %0b, expected %0b", last, want.last));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PIX_W-1:0]     pixel_out;
	logic                 frame_last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_idx_t             cfg_index = CFG_KERNEL_TOP;
	logic [KROW_W-1:0]    cfg_data = '0;

	int                   idle_pct = 0;
	int                   stall_pct = 0;
	int                   quiet_cycles = 0;
	conv_scoreboard       sb;

	conv3x3_divide_offset_clamp i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.frame_last (frame_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(pixel_out, frame_last);
			if (in_valid && !in_stall)
				sb.note_pixel(pixel_in);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [KROW_W-1:0] random_kernel_row();
		logic [KROW_W-1:0] row;
		for (int j = 0; j < 3; j++) begin
			case ($urandom_range(0, 4))
				0:       row[8*j +: 8] = 8'h80;
				1:       row[8*j +: 8] = 8'h7F;
				2:       row[8*j +: 8] = 8'($urandom_range(0, 255));
				default: row[8*j +: 8] = 8'($urandom_range(0, 8) - 4);
			endcase
		end
		return row;
	endfunction

	// hold valid until the item is taken; leave it high for the caller to decide
	task automatic send_pixel(input logic [PIX_W-1:0] value);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_random_frame(input int cols, input int rows);
		repeat (cols * rows)
			send_pixel(random_pixel());
	endtask

	// drop valid, wait for every queued result, then let the last border item settle
	task automatic await_idle();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg_item(input cfg_idx_t idx, input logic [KROW_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(
		input logic [KROW_W-1:0] k_top,
		input logic [KROW_W-1:0] k_mid,
		input logic [KROW_W-1:0] k_bot,
		input logic [DIV_W-1:0]  dv,
		input logic [OFF_W-1:0]  ofs,
		input logic [WID_W-1:0]  w,
		input logic [HGT_W-1:0]  h
	);
		write_reg_item(CFG_KERNEL_TOP, k_top);
		write_reg_item(CFG_KERNEL_MIDDLE, k_mid);
		write_reg_item(CFG_KERNEL_BOTTOM, k_bot);
		write_reg_item(CFG_DIVISOR, KROW_W'(dv));
		write_reg_item(CFG_OFFSET, KROW_W'(ofs));
		write_reg_item(CFG_WIDTH, KROW_W'(w));
		write_reg_item(CFG_HEIGHT, KROW_W'(h));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase;
		int random_items;
		int cols;
		int rows;
		logic [KROW_W-1:0] k_top, k_mid, k_bot;
		logic [DIV_W-1:0]  dv;
		logic [OFF_W-1:0]  ofs;
		logic [WID_W-1:0]  w_set;
		logic [HGT_W-1:0]  h_set;

		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// largest positive sum, zero divisor, most negative offset, undersized geometry
		apply_config(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 9'h100, 11'd0, 16'd2);
		repeat (9) send_pixel(8'hFF);
		await_idle();

		// small negative sum: quotient truncates toward zero, largest offset
		apply_config(24'h808080, 24'h80FF80, 24'h808080, 8'd2, 9'h0FF, 11'd3, 16'd3);
		for (int i = 0; i < 9; i++)
			send_pixel((i == 4) ? 8'd5 : 8'd0);
		await_idle();

		// most negative sum clamps to zero
		apply_config(24'h808080, 24'h808080, 24'h808080, 8'd1, 9'd0, 11'd3, 16'd3);
		repeat (9) send_pixel(8'hFF);
		await_idle();

		// oversized width on the tallest frame: one row at the clamped width, then part of the next
		apply_config(SOBEL_OUTER, SOBEL_CENTRE, SOBEL_OUTER, 8'd1, 9'd127, 11'd2047,
			16'hFFFF);
		send_random_frame(MAX_WIDTH, 1);
		repeat (5) send_pixel(random_pixel());
		await_idle();
		// shrink to five columns and three rows: the next pixel ends row 1, row 2 ends the image
		apply_config(SOBEL_OUTER, SOBEL_CENTRE, SOBEL_OUTER, 8'd1, 9'd127, 11'd5, 16'd1);
		repeat (6) send_pixel(random_pixel());
		await_idle();

		phase = 0;
		random_items = 0;
		while ((random_items < RANDOM_ITEMS) || (phase < 4)) begin
			case (phase % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					idle_pct = 15;
					stall_pct = 15;
				end
			endcase
			if ($urandom_range(0, 3) == 0) begin
				dv = 8'd1;
				ofs = 9'd0;
				case ($urandom_range(0, 2))
					0: begin
						k_top = SHARPEN_OUTER;
						k_mid = SHARPEN_CENTRE;
						k_bot = SHARPEN_OUTER;
					end
					1: begin
						k_top = SOBEL_OUTER;
						k_mid = SOBEL_CENTRE;
						k_bot = SOBEL_OUTER;
						ofs = 9'd127;
					end
					default: begin
						k_top = CROSS_OUTER;
						k_mid = CROSS_CENTRE;
						k_bot = CROSS_OUTER;
					end
				endcase
			end else begin
				k_top = random_kernel_row();
				k_mid = random_kernel_row();
				k_bot = random_kernel_row();
				case ($urandom_range(0, 5))
					0:       dv = 8'd0;
					1:       dv = 8'd255;
					2, 3:    dv = 8'($urandom_range(1, 16));
					default: dv = 8'($urandom_range(0, 255));
				endcase
				ofs = 9'($urandom_range(0, 511));
			end
			w_set = ($urandom_range(0, 9) == 0) ? 11'($urandom_range(0, 2))
				: 11'($urandom_range(3, 14));
			h_set = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2))
				: 16'($urandom_range(3, 8));
			apply_config(k_top, k_mid, k_bot, dv, ofs, w_set, h_set);
			cols = (w_set < 3) ? 3 : int'(w_set);
			rows = (h_set < 3) ? 3 : int'(h_set);
			repeat ($urandom_range(1, 3)) begin
				send_random_frame(cols, rows);
				random_items += cols * rows;
			end
			await_idle();
			phase++;
		end

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
